### hdl/enrbc_pkg.sv
package enrbc_pkg;

	localparam int RING_ADDR_BITS = 16;
	localparam int PAGE_BYTES     = 256;
	localparam int PAGE_BITS      = $clog2(PAGE_BYTES);
	localparam int RING_DEPTH     = 1 << RING_ADDR_BITS;

	localparam logic [2:0] CMD_REG_RD   = 3'd0;
	localparam logic [2:0] CMD_REG_WR   = 3'd1;
	localparam logic [2:0] CMD_RX_START = 3'd2;
	localparam logic [2:0] CMD_RX_BYTE  = 3'd3;
	localparam logic [2:0] CMD_TX_FETCH = 3'd4;

	localparam logic [4:0] OFF_CMD     = 5'd0;
	localparam logic [4:0] OFF_PSTART  = 5'd1;
	localparam logic [4:0] OFF_PSTOP   = 5'd2;
	localparam logic [4:0] OFF_BNDRY   = 5'd3;
	localparam logic [4:0] OFF_TPSR    = 5'd4;
	localparam logic [4:0] OFF_TBCR0   = 5'd5;
	localparam logic [4:0] OFF_TBCR1   = 5'd6;
	localparam logic [4:0] OFF_ISR     = 5'd7;
	localparam logic [4:0] OFF_RSAR0   = 5'd8;
	localparam logic [4:0] OFF_RSAR1   = 5'd9;
	localparam logic [4:0] OFF_RBCR0   = 5'd10;
	localparam logic [4:0] OFF_RBCR1   = 5'd11;
	localparam logic [4:0] OFF_TCR     = 5'd13;
	localparam logic [4:0] OFF_IMR     = 5'd15;
	localparam logic [4:0] OFF_DATA0   = 5'd16;
	localparam logic [4:0] OFF_DATA1   = 5'd17;
	localparam logic [4:0] OFF_RESET   = 5'd31;

	localparam logic [7:0] CMD_WR_MASK = 8'hFB;
	localparam logic [7:0] IRQ_RST     = 8'h80;
	localparam logic [7:0] IRQ_RDC     = 8'h40;
	localparam logic [7:0] IRQ_PTX     = 8'h02;
	localparam logic [7:0] IRQ_PRX     = 8'h01;
	localparam logic [7:0] RX_HDR_STAT = 8'h01;

	function automatic logic [15:0] page_addr(input logic [7:0] pg);
		page_addr = 16'(pg) << PAGE_BITS;
	endfunction

	// step a ring pointer, wrapping stop page -> start page
	function automatic logic [15:0] adv_ptr(input logic [15:0] p, input logic [7:0] pstart,
			input logic [7:0] pstop);
		logic [15:0] n;
		n = p + 16'd1;
		if (n == page_addr(pstop)) begin
			n = page_addr(pstart);
		end
		adv_ptr = n;
	endfunction

endpackage

### hdl/enrbc_ram.sv
module enrbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hdl/ethernet_nic_ring_buffer_controller.sv
// channel  | dir | signals                          | contents
// s_axis   | in  | s_tvalid s_tready s_tdata[39:0]  | command, reg_offset, write_data,
//          |     |                                  | frame_length, rx_byte
// m_axis   | out | m_tvalid m_tready m_tdata[39:0]  | read_data, irq_pulse, tx_length, tx_byte
//          |     | m_tuser m_tlast                  | tx_valid, tx_last
// cfg      | in  | cfg_we cfg_wdata[7:0]            | loopback_read_byte
//
// Register beats and receive bytes complete on acceptance; data port reads and transmit
// fetches wait for the one ring read port (registered), and a receive frame start writes
// the four header bytes one per cycle through the single ring write port.
// After reset the ring is zeroed by a sweep over all 2^RING_ADDR_BITS addresses (65536)
// with s_tready low; cfg writes are taken throughout.
// s_tready also waits for the result register to be free or drained in the same cycle.
module ethernet_nic_ring_buffer_controller (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // command[2:0] reg_offset[7:3] write_data[15:8]
	                               // frame_length[31:16] rx_byte[39:32]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // read_data[7:0] irq_pulse[8] tx_length[24:9]
	                               // tx_byte[32:25] zeros[39:33]
	output logic        m_tuser,   // tx_valid
	output logic        m_tlast,   // tx_last
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata
);

	localparam int AW = enrbc_pkg::RING_ADDR_BITS;

	// sequencer states
	localparam logic [1:0] ST_RUN = 2'd0;
	localparam logic [1:0] ST_RD  = 2'd1;  // ring read data arrives this cycle
	localparam logic [1:0] ST_HDR = 2'd2;  // receive header writes

	logic [1:0]  st_q, st_d;
	logic [1:0]  hdr_cnt_q, hdr_cnt_d;
	logic        clr_done_q;
	logic [AW-1:0] clr_addr_q;
	logic        rd_tx_q, rd_tx_d;     // pending read is a transmit fetch
	logic        txl_q, txl_d;
	logic [15:0] hlen_q, hlen_d;

	logic [7:0]  lb_q;
	logic [7:0]  cmd_q, cmd_d, pstart_q, pstart_d, pstop_q, pstop_d, bnd_q, bnd_d;
	logic [7:0]  cur_q, cur_d, isr_q, isr_d, imr_q, imr_d, tcr_q, tcr_d, tsr_q, tsr_d;
	logic [15:0] tsa_q, tsa_d, tcnt_q, tcnt_d, rsa_q, rsa_d, rbc_q, rbc_d;
	logic [15:0] raddr_q, raddr_d, laddr_q, laddr_d, txrem_q, txrem_d, rxrem_q, rxrem_d;

	logic        m_tvalid_q;
	logic [7:0]  o_rd_q, o_txb_q;
	logic        o_irq_q, o_txv_q, o_txl_q;
	logic [15:0] o_len_q;

	logic        acc;
	logic [2:0]  in_cmd;
	logic [4:0]  in_off;
	logic [7:0]  in_wd, in_rb;
	logic [15:0] in_flen;
	logic [1:0]  page;
	logic        loopback;

	logic        ld;
	logic [7:0]  ld_rd, ld_txb;
	logic        ld_irq, ld_txv, ld_txl;
	logic [15:0] ld_len;

	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [7:0]    ram_wdata, ram_rdata;

	logic [15:0] cnt4;
	logic [7:0]  nxt;
	logic [7:0]  hdr_byte;
	logic [15:0] tx_ptr;

	assign in_cmd  = s_tdata[2:0];
	assign in_off  = s_tdata[7:3];
	assign in_wd   = s_tdata[15:8];
	assign in_flen = s_tdata[31:16];
	assign in_rb   = s_tdata[39:32];

	assign page     = cmd_q[7:6];
	assign loopback = (tcr_q[2:1] == 2'b01);

	assign s_tready = clr_done_q && (st_q == ST_RUN) && (!m_tvalid_q || m_tready);
	assign acc      = s_tvalid && s_tready;

	assign cnt4   = in_flen + 16'd4;
	assign tx_ptr = tsa_q + (tcnt_q - txrem_q);

	always_comb begin
		unique case (hdr_cnt_q)
			2'd0: hdr_byte = enrbc_pkg::RX_HDR_STAT;
			2'd1: hdr_byte = cur_q;  // already the next page
			2'd2: hdr_byte = hlen_q[7:0];
			2'd3: hdr_byte = hlen_q[15:8];
			default: hdr_byte = '0;
		endcase
	end

	always_comb begin
		st_d = st_q; hdr_cnt_d = hdr_cnt_q; rd_tx_d = rd_tx_q; txl_d = txl_q; hlen_d = hlen_q;
		cmd_d = cmd_q; pstart_d = pstart_q; pstop_d = pstop_q; bnd_d = bnd_q; cur_d = cur_q;
		isr_d = isr_q; imr_d = imr_q; tcr_d = tcr_q; tsr_d = tsr_q;
		tsa_d = tsa_q; tcnt_d = tcnt_q; rsa_d = rsa_q; rbc_d = rbc_q;
		raddr_d = raddr_q; laddr_d = laddr_q; txrem_d = txrem_q; rxrem_d = rxrem_q;
		ld = 1'b0; ld_rd = '0; ld_irq = 1'b0; ld_len = '0; ld_txv = 1'b0; ld_txb = '0;
		ld_txl = 1'b0;
		ram_we = 1'b0; ram_waddr = laddr_q[AW-1:0]; ram_wdata = '0;
		ram_raddr = raddr_q[AW-1:0];
		nxt = '0;

		if (!clr_done_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
		end else if (st_q == ST_HDR) begin
			if (laddr_q != enrbc_pkg::page_addr(bnd_q)) begin
				ram_we    = 1'b1;
				ram_waddr = laddr_q[AW-1:0];
				ram_wdata = hdr_byte;
				laddr_d   = enrbc_pkg::adv_ptr(laddr_q, pstart_q, pstop_q);
			end
			hdr_cnt_d = hdr_cnt_q + 2'd1;
			if (hdr_cnt_q == 2'd3) begin
				st_d = ST_RUN;
			end
		end else if (st_q == ST_RD) begin
			ld = 1'b1;
			if (rd_tx_q) begin
				ld_txv = 1'b1;
				ld_txb = ram_rdata;
				ld_txl = txl_q;
			end else begin
				ld_rd = ram_rdata;
			end
			st_d = ST_RUN;
		end else if (acc) begin
			ld = 1'b1;
			unique case (in_cmd)
				enrbc_pkg::CMD_REG_RD: begin
					if (in_off == enrbc_pkg::OFF_CMD) begin
						ld_rd = cmd_q;
					end else if (in_off == enrbc_pkg::OFF_DATA0 ||
							in_off == enrbc_pkg::OFF_DATA1) begin
						if (loopback) begin
							ld_rd = lb_q;
						end else begin
							ld        = 1'b0;
							ram_raddr = raddr_q[AW-1:0];
							raddr_d   = enrbc_pkg::adv_ptr(raddr_q, pstart_q, pstop_q);
							rd_tx_d   = 1'b0;
							st_d      = ST_RD;
						end
					end else if (page == 2'd1 && in_off == enrbc_pkg::OFF_ISR) begin
						ld_rd = cur_q;
					end else if (page == 2'd0) begin
						unique case (in_off)
							enrbc_pkg::OFF_PSTART: ld_rd = laddr_q[7:0];
							enrbc_pkg::OFF_PSTOP:  ld_rd = laddr_q[15:8];
							enrbc_pkg::OFF_BNDRY:  ld_rd = bnd_q;
							enrbc_pkg::OFF_TPSR:   ld_rd = tsr_q;
							enrbc_pkg::OFF_ISR:    ld_rd = isr_q;
							enrbc_pkg::OFF_RSAR0:  ld_rd = raddr_q[7:0];
							enrbc_pkg::OFF_RSAR1:  ld_rd = raddr_q[15:8];
							default:               ld_rd = '0;
						endcase
					end
				end
				enrbc_pkg::CMD_REG_WR: begin
					if (in_off == enrbc_pkg::OFF_CMD) begin
						cmd_d = in_wd & enrbc_pkg::CMD_WR_MASK;
						if (in_wd[0]) begin
							isr_d = isr_d | enrbc_pkg::IRQ_RST;
						end
						if (in_wd[1]) begin
							isr_d = isr_d & ~enrbc_pkg::IRQ_RST;
						end
						if (in_wd[2]) begin
							tsr_d   = 8'h01;
							isr_d   = isr_d | enrbc_pkg::IRQ_PTX;
							ld_irq  = |(imr_q & enrbc_pkg::IRQ_PTX);
							ld_len  = tcnt_q;
							txrem_d = tcnt_q;
						end
						if (in_wd[5:3] != 3'd0) begin
							isr_d  = isr_d | enrbc_pkg::IRQ_RDC;
							ld_irq = ld_irq | (|(imr_q & enrbc_pkg::IRQ_RDC));
						end
					end else if (in_off == enrbc_pkg::OFF_DATA0 ||
							in_off == enrbc_pkg::OFF_DATA1) begin
						ram_we    = 1'b1;
						ram_waddr = raddr_q[AW-1:0];
						ram_wdata = in_wd;
						raddr_d   = enrbc_pkg::adv_ptr(raddr_q, pstart_q, pstop_q);
					end else if (in_off == enrbc_pkg::OFF_RESET) begin
						isr_d = isr_q | enrbc_pkg::IRQ_RST;
					end else if (page == 2'd1 && in_off == enrbc_pkg::OFF_ISR) begin
						cur_d = in_wd;
					end else if (page == 2'd0) begin
						unique case (in_off)
							enrbc_pkg::OFF_PSTART: pstart_d = in_wd;
							enrbc_pkg::OFF_PSTOP:  pstop_d  = in_wd;
							enrbc_pkg::OFF_BNDRY:  bnd_d    = in_wd;
							enrbc_pkg::OFF_TPSR:   tsa_d    = enrbc_pkg::page_addr(in_wd);
							enrbc_pkg::OFF_TBCR0:  tcnt_d   = {tcnt_q[15:8], in_wd};
							enrbc_pkg::OFF_TBCR1:  tcnt_d   = {in_wd, tcnt_q[7:0]};
							enrbc_pkg::OFF_ISR:    isr_d    = isr_q & ~in_wd;
							enrbc_pkg::OFF_RSAR0: begin
								rsa_d   = {rsa_q[15:8], in_wd};
								raddr_d = {raddr_q[15:8], in_wd};
							end
							enrbc_pkg::OFF_RSAR1: begin
								rsa_d   = {in_wd, rsa_q[7:0]};
								raddr_d = {in_wd, raddr_q[7:0]};
							end
							enrbc_pkg::OFF_RBCR0:  rbc_d    = {rbc_q[15:8], in_wd};
							enrbc_pkg::OFF_RBCR1:  rbc_d    = {in_wd, rbc_q[7:0]};
							enrbc_pkg::OFF_TCR:    tcr_d    = in_wd;
							enrbc_pkg::OFF_IMR:    imr_d    = in_wd;
							default: ;
						endcase
					end
				end
				enrbc_pkg::CMD_RX_START: begin
					laddr_d = enrbc_pkg::page_addr(cur_q);
					nxt     = cur_q + cnt4[15:8] + 8'd1;
					if (nxt >= pstop_q) begin
						nxt = pstart_q + (nxt - pstop_q);
					end
					cur_d     = nxt;
					hlen_d    = cnt4;
					rxrem_d   = in_flen;
					hdr_cnt_d = 2'd0;
					st_d      = ST_HDR;
					if (in_flen == 16'd0) begin
						isr_d  = isr_q | enrbc_pkg::IRQ_PRX;
						ld_irq = |(imr_q & enrbc_pkg::IRQ_PRX);
					end
				end
				enrbc_pkg::CMD_RX_BYTE: begin
					if (rxrem_q != 16'd0) begin
						if (laddr_q != enrbc_pkg::page_addr(bnd_q)) begin
							ram_we    = 1'b1;
							ram_waddr = laddr_q[AW-1:0];
							ram_wdata = in_rb;
							laddr_d   = enrbc_pkg::adv_ptr(laddr_q, pstart_q, pstop_q);
						end
						rxrem_d = rxrem_q - 16'd1;
						if (rxrem_q == 16'd1) begin
							isr_d  = isr_q | enrbc_pkg::IRQ_PRX;
							ld_irq = |(imr_q & enrbc_pkg::IRQ_PRX);
						end
					end
				end
				enrbc_pkg::CMD_TX_FETCH: begin
					if (txrem_q != 16'd0) begin
						ld        = 1'b0;
						ram_raddr = tx_ptr[AW-1:0];
						rd_tx_d   = 1'b1;
						txl_d     = (txrem_q == 16'd1);
						txrem_d   = txrem_q - 16'd1;
						st_d      = ST_RD;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RUN; hdr_cnt_q <= '0; clr_done_q <= 1'b0; clr_addr_q <= '0;
			rd_tx_q <= 1'b0; txl_q <= 1'b0; hlen_q <= '0; lb_q <= '0;
			cmd_q <= '0; pstart_q <= '0; pstop_q <= '0; bnd_q <= '0; cur_q <= '0;
			isr_q <= '0; imr_q <= '0; tcr_q <= '0; tsr_q <= '0;
			tsa_q <= '0; tcnt_q <= '0; rsa_q <= '0; rbc_q <= '0;
			raddr_q <= '0; laddr_q <= '0; txrem_q <= '0; rxrem_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (!clr_done_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (&clr_addr_q) begin
					clr_done_q <= 1'b1;
				end
			end
			if (cfg_we) begin
				lb_q <= cfg_wdata;
			end
			st_q <= st_d; hdr_cnt_q <= hdr_cnt_d; rd_tx_q <= rd_tx_d; txl_q <= txl_d;
			hlen_q <= hlen_d;
			cmd_q <= cmd_d; pstart_q <= pstart_d; pstop_q <= pstop_d; bnd_q <= bnd_d;
			cur_q <= cur_d; isr_q <= isr_d; imr_q <= imr_d; tcr_q <= tcr_d; tsr_q <= tsr_d;
			tsa_q <= tsa_d; tcnt_q <= tcnt_d; rsa_q <= rsa_d; rbc_q <= rbc_d;
			raddr_q <= raddr_d; laddr_q <= laddr_d; txrem_q <= txrem_d; rxrem_q <= rxrem_d;
			if (ld) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (ld) begin
			o_rd_q  <= ld_rd;
			o_irq_q <= ld_irq;
			o_len_q <= ld_len;
			o_txv_q <= ld_txv;
			o_txb_q <= ld_txb;
			o_txl_q <= ld_txl;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'd0, o_txb_q, o_len_q, o_irq_q, o_rd_q};
	assign m_tuser  = o_txv_q;
	assign m_tlast  = o_txl_q;

	enrbc_ram #(
		.WIDTH(8),
		.DEPTH(enrbc_pkg::RING_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	a_no_acc_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!clr_done_q |-> !acc) else $error("beat taken during ring clear");
	a_rd_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_RD) |-> !m_tvalid_q) else $error("result register busy at read return");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ld |-> (!m_tvalid_q || m_tready)) else $error("result overwritten");
	a_hdr_len: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && in_cmd == enrbc_pkg::CMD_RX_START) |=> (st_q == ST_HDR && hdr_cnt_q == 2'd0))
		else $error("header sequence not started");

endmodule
